/* rtl/wrc_pkg.sv */
// ----------------------------------------------------------------------------
// wrc_pkg
// Types and constants shared by the weightless RAM classifier modules.
// ----------------------------------------------------------------------------
package wrc_pkg;

    localparam logic       OP_TRAIN          = 1'b0;
    localparam logic       OP_PREDICT        = 1'b1;
    localparam logic [3:0] CLASS_COUNT_RESET = 4'd10;
    localparam logic [7:0] VOTE_MAX          = 8'd255;

    typedef struct packed {
        logic       opcode;
        logic [7:0] tuple_address;
        logic [3:0] class_label;
        logic       last_tuple;
    } t_in;

    typedef struct packed {
        logic [3:0] class_index;
        logic [7:0] vote_count;
        logic       last_class;
    } t_out;

    // decoded tuple command passed from the front end to the back end
    typedef struct packed {
        logic       vote;    // predict tuple inside the RAM range
        logic       mark;    // train tuple inside the RAM range with a valid label
        logic [3:0] label;
        logic       last;    // sample ends here, votes are cleared
        logic       report;  // sample ends on a predict tuple, report all classes
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_EMIT
    } t_state;

endpackage

/* rtl/weightless_ram_classifier_unit.sv */
// ----------------------------------------------------------------------------
// weightless_ram_classifier_unit
// WiSARD-style weightless classifier with training and voting over tuples.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2^(clog2(MAX_RAMS) + TUPLE_BITS) words of
// the class-mark memory (32768 at the defaults) to zero, one word per cycle,
// and stalls its input until the sweep is done. Then it takes one tuple per
// cycle while the queue is not full: the front end numbers the RAMs and
// decodes each tuple, a four-entry queue decouples it from the back end,
// which does one read-modify-write of the class-mark memory per tuple over
// a read stage and a write stage. When a predict sample ends, the back end
// stops reading the queue while the last tuple votes and then while it
// reports the classes (class_count clamped to one .. CLASS_SLOTS), sending
// one result per class through the output register and waiting while the
// output is stalled; the queue keeps absorbing tuples until it is full.
// Results leave in class order with last_class set on the final one.
// class_count should only be written while no tuple is in flight.
// ----------------------------------------------------------------------------
module weightless_ram_classifier_unit #(
    parameter int TUPLE_BITS  = 8,
    parameter int MAX_RAMS    = 128,
    parameter int CLASS_SLOTS = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  wrc_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output wrc_pkg::t_out  o_out_data,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_data
);

    localparam int POS_IW = (MAX_RAMS > 1) ? $clog2(MAX_RAMS) : 1;
    localparam int MEM_AW = POS_IW + TUPLE_BITS;
    localparam int CMD_W  = $bits(wrc_pkg::t_cmd);
    localparam int Q_W    = CMD_W + MEM_AW;

    logic               w_push;
    wrc_pkg::t_cmd      w_front_cmd;
    logic [MEM_AW-1:0]  w_front_addr;
    logic               w_full;
    logic               w_empty;
    logic               w_pop;
    logic               w_clearing;
    logic [Q_W-1:0]     w_q_out;
    wrc_pkg::t_cmd      w_back_cmd;
    logic [MEM_AW-1:0]  w_back_addr;

    assign w_back_cmd  = w_q_out[Q_W-1:MEM_AW];
    assign w_back_addr = w_q_out[MEM_AW-1:0];

    wrc_front #(
        .TUPLE_BITS  (TUPLE_BITS),
        .MAX_RAMS    (MAX_RAMS),
        .CLASS_SLOTS (CLASS_SLOTS),
        .MEM_AW      (MEM_AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_full     (w_full),
        .i_clearing (w_clearing),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd),
        .o_addr     (w_front_addr)
    );

    wrc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_cmd, w_front_addr}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    wrc_back #(
        .CLASS_SLOTS (CLASS_SLOTS),
        .MEM_AW      (MEM_AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_cmd       (w_back_cmd),
        .i_addr      (w_back_addr),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/wrc_front.sv */
// ----------------------------------------------------------------------------
// wrc_front
// Accepts tuples, tracks the RAM position and decodes each tuple into a
// command with its class-mark memory address.
// ----------------------------------------------------------------------------
module wrc_front #(
    parameter int TUPLE_BITS  = 8,
    parameter int MAX_RAMS    = 128,
    parameter int CLASS_SLOTS = 10,
    parameter int MEM_AW      = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wrc_pkg::t_in        i_in_data,
    input  logic                i_full,
    input  logic                i_clearing,
    output logic                o_push,
    output wrc_pkg::t_cmd       o_cmd,
    output logic [MEM_AW-1:0]   o_addr
);

    localparam int POS_W   = $clog2(MAX_RAMS + 1);
    localparam int POS_IW  = MEM_AW - TUPLE_BITS;
    localparam int ADDR_XW = (TUPLE_BITS > 8) ? TUPLE_BITS : 8;

    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic               w_accept;
    logic               w_active;
    logic [ADDR_XW-1:0] w_addr_x;

    assign o_in_stall = i_full | i_clearing;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_active   = (32'(r_pos) < 32'(MAX_RAMS));
    assign w_addr_x   = ADDR_XW'(i_in_data.tuple_address);

    always_comb begin
        o_cmd.vote   = w_active & (i_in_data.opcode == wrc_pkg::OP_PREDICT);
        o_cmd.mark   = w_active & (i_in_data.opcode == wrc_pkg::OP_TRAIN)
                     & (5'(i_in_data.class_label) < 5'(CLASS_SLOTS));
        o_cmd.label  = i_in_data.class_label;
        o_cmd.last   = i_in_data.last_tuple;
        o_cmd.report = i_in_data.last_tuple & (i_in_data.opcode == wrc_pkg::OP_PREDICT);
        o_addr       = {r_pos[POS_IW-1:0], w_addr_x[TUPLE_BITS-1:0]};
        o_push       = w_accept;
    end

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (i_in_data.last_tuple) begin
                n_pos = '0;
            end else if (w_active) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

/* rtl/wrc_queue.sv */
// ----------------------------------------------------------------------------
// wrc_queue
// Four-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module wrc_queue #(
    parameter int WIDTH = 23
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_entry [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;
    logic [PW:0]      n_count;

    assign o_data  = r_entry[r_rd_ptr];
    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

/* rtl/wrc_back.sv */
// ----------------------------------------------------------------------------
// wrc_back
// Class-mark memory read-modify-write, vote counters, result reporting and
// the memory clearing pass after reset.
// ----------------------------------------------------------------------------
module wrc_back #(
    parameter int CLASS_SLOTS = 10,
    parameter int MEM_AW      = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  wrc_pkg::t_cmd      i_cmd,
    input  logic [MEM_AW-1:0]  i_addr,
    output logic               o_pop,
    output logic               o_clearing,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wrc_pkg::t_out      o_out_data
);

    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int SIW       = (CLASS_SLOTS > 1) ? $clog2(CLASS_SLOTS) : 1;

    logic [CLASS_SLOTS-1:0] r_marks [MEM_DEPTH];

    wrc_pkg::t_state        r_state;
    wrc_pkg::t_state        n_state;
    logic [MEM_AW-1:0]      r_clr_addr;
    logic [3:0]             r_class_count;

    logic                   r_s2_valid;
    wrc_pkg::t_cmd          r_s2_cmd;
    logic [MEM_AW-1:0]      r_s2_addr;
    logic [CLASS_SLOTS-1:0] r_rd_word;
    logic                   r_byp_hit;
    logic [CLASS_SLOTS-1:0] r_byp_word;

    logic [7:0]             r_votes [CLASS_SLOTS];
    logic [7:0]             n_votes [CLASS_SLOTS];
    logic [SIW-1:0]         r_emit_idx;
    logic [SIW-1:0]         r_emit_last;
    logic [3:0]             w_last4;

    logic                   r_out_valid;
    wrc_pkg::t_out          r_out_data;

    logic                   w_issue;
    logic                   w_out_free;
    logic                   w_emit_load;
    logic                   w_emit_done;
    logic                   w_clr_done;
    logic                   w_mark_wr;
    logic                   w_wr_en;
    logic [MEM_AW-1:0]      w_wr_addr;
    logic [CLASS_SLOTS-1:0] w_wr_word;
    logic [CLASS_SLOTS-1:0] w_s2_word;
    logic [CLASS_SLOTS-1:0] w_label_bit;

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_clr_done = &r_clr_addr;
    assign w_s2_word  = r_byp_hit ? r_byp_word : r_rd_word;
    assign w_mark_wr  = r_s2_valid & r_s2_cmd.mark;

    always_comb begin
        for (int j = 0; j < CLASS_SLOTS; j++) begin
            w_label_bit[j] = (r_s2_cmd.label == 4'(j));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wrc_pkg::ST_CLEAR: begin
                if (w_clr_done) begin
                    n_state = wrc_pkg::ST_RUN;
                end
            end
            wrc_pkg::ST_RUN: begin
                if (r_s2_valid && r_s2_cmd.report) begin
                    n_state = wrc_pkg::ST_EMIT;
                end
            end
            wrc_pkg::ST_EMIT: begin
                if (w_out_free && r_emit_idx == r_emit_last) begin
                    n_state = wrc_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = wrc_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_clearing  = 1'b0;
        w_issue     = 1'b0;
        w_emit_load = 1'b0;
        w_emit_done = 1'b0;
        case (r_state)
            wrc_pkg::ST_CLEAR: begin
                o_clearing = 1'b1;
            end
            wrc_pkg::ST_RUN: begin
                // hold new reads while a reporting tuple finishes its votes
                w_issue = ~i_empty & ~(r_s2_valid & r_s2_cmd.report);
            end
            wrc_pkg::ST_EMIT: begin
                w_emit_load = w_out_free;
                w_emit_done = w_out_free & (r_emit_idx == r_emit_last);
            end
            default: begin
                o_clearing = 1'b0;
            end
        endcase
    end

    assign o_pop = w_issue;

    always_comb begin
        w_wr_en   = o_clearing | w_mark_wr;
        w_wr_addr = o_clearing ? r_clr_addr : r_s2_addr;
        w_wr_word = o_clearing ? '0 : (w_s2_word | w_label_bit);
    end

    // number of reported classes, clamped to one .. CLASS_SLOTS
    always_comb begin
        if (r_class_count == 4'd0) begin
            w_last4 = 4'd0;
        end else if (5'(r_class_count) >= 5'(CLASS_SLOTS)) begin
            w_last4 = 4'(CLASS_SLOTS - 1);
        end else begin
            w_last4 = r_class_count - 4'd1;
        end
    end

    always_comb begin
        n_votes = r_votes;
        if (r_s2_valid && r_s2_cmd.vote) begin
            for (int j = 0; j < CLASS_SLOTS; j++) begin
                if (w_s2_word[j] && r_votes[j] != wrc_pkg::VOTE_MAX) begin
                    n_votes[j] = r_votes[j] + 8'd1;
                end
            end
        end
        if ((r_s2_valid && r_s2_cmd.last && !r_s2_cmd.report) || w_emit_done) begin
            for (int j = 0; j < CLASS_SLOTS; j++) begin
                n_votes[j] = '0;
            end
        end
    end

    // class-mark memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_marks[w_wr_addr] <= w_wr_word;
        end
        if (w_issue) begin
            r_rd_word <= r_marks[i_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s2_cmd   <= i_cmd;
            r_s2_addr  <= i_addr;
            r_byp_word <= w_wr_word;
        end
        if (w_emit_load) begin
            r_out_data.class_index <= 4'(r_emit_idx);
            r_out_data.vote_count  <= r_votes[r_emit_idx];
            r_out_data.last_class  <= (r_emit_idx == r_emit_last);
        end
        if (r_state == wrc_pkg::ST_RUN && n_state == wrc_pkg::ST_EMIT) begin
            r_emit_last <= SIW'(w_last4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= wrc_pkg::ST_CLEAR;
            r_clr_addr    <= '0;
            r_class_count <= wrc_pkg::CLASS_COUNT_RESET;
            r_s2_valid    <= 1'b0;
            r_byp_hit     <= 1'b0;
            r_emit_idx    <= '0;
            r_out_valid   <= 1'b0;
            for (int j = 0; j < CLASS_SLOTS; j++) begin
                r_votes[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_clearing) begin
                r_clr_addr <= r_clr_addr + MEM_AW'(1);
            end
            if (i_cfg_we) begin
                r_class_count <= i_cfg_data;
            end
            r_s2_valid <= w_issue;
            // the word written this cycle is newer than the one being read
            if (w_issue) begin
                r_byp_hit <= w_mark_wr & (r_s2_addr == i_addr);
            end
            if (w_emit_done) begin
                r_emit_idx <= '0;
            end else if (w_emit_load) begin
                r_emit_idx <= r_emit_idx + SIW'(1);
            end
            if (w_out_free) begin
                r_out_valid <= w_emit_load;
            end
            r_votes <= n_votes;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
